// ===== hdl/dcth_pkg.sv =====
// ----------------------------------------------------------------------------
// dcth_pkg
// Shared widths, register indexes and status codes for the device cycle to
// host time converter.
// ----------------------------------------------------------------------------
package dcth_pkg;

   localparam int CYCLE_W = 64;
   localparam int TIME_W  = 64;
   localparam int RATE_W  = 48;
   localparam int DATA_W  = 64;
   localparam int INDEX_W = 2;

   // Partial product split of the 64 x 48 multiply.
   localparam int HALF_W = 32;
   localparam int RATE_HI_W = RATE_W - HALF_W;
   localparam int PROD_W = CYCLE_W + RATE_W;

   typedef enum logic [INDEX_W-1:0] {
      REG_REF_CYCLE       = 2'd0,
      REG_HOST_ANCHOR_NS  = 2'd1,
      REG_RATE_NS_PER_CYC = 2'd2,
      REG_OFFSET_NS       = 2'd3
   } reg_index_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_RANGE = 1'b1
   } status_type;

   // One nanosecond per cycle in Q16.32.
   localparam logic [RATE_W-1:0] RATE_RESET = 48'h0001_0000_0000;

endpackage

// ===== hdl/dcth_mul.sv =====
// ----------------------------------------------------------------------------
// dcth_mul
// Three-stage 64 x 48 unsigned multiplier built from four partial products,
// with a direction flag carried alongside and valid/ready flow control.
// ----------------------------------------------------------------------------
module dcth_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [dcth_pkg::CYCLE_W-1:0]   in_dist,
   input  logic                           in_fwd,
   input  logic [dcth_pkg::RATE_W-1:0]    rate,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [dcth_pkg::PROD_W-1:0]    out_prod,
   output logic                           out_fwd
);

   localparam int HW  = dcth_pkg::HALF_W;
   localparam int RHW = dcth_pkg::RATE_HI_W;
   localparam int PW  = dcth_pkg::PROD_W;

   logic                 m1_v_ff, m1_v_in, m1_rdy;
   logic                 m2_v_ff, m2_v_in, m2_rdy;
   logic                 m3_v_ff, m3_v_in, m3_rdy;

   logic [2*HW-1:0]      pp0_ff, pp0_in;
   logic [HW+RHW-1:0]    pp1_ff, pp1_in;
   logic [2*HW-1:0]      pp2_ff, pp2_in;
   logic [HW+RHW-1:0]    pp3_ff, pp3_in;
   logic                 m1_fwd_ff;

   logic [2*HW:0]        mid_ff, mid_in;
   logic [2*HW-1:0]      m2_lo_ff;
   logic [HW+RHW-1:0]    m2_hi_ff;
   logic                 m2_fwd_ff;

   logic [PW-1:0]        prod_ff, prod_in;
   logic                 m3_fwd_ff;

   // A stage takes new data when it is empty or its contents move on.
   assign m3_rdy   = !m3_v_ff || out_ready;
   assign m2_rdy   = !m2_v_ff || m3_rdy;
   assign m1_rdy   = !m1_v_ff || m2_rdy;
   assign in_ready = m1_rdy;

   assign m1_v_in = m1_rdy ? in_valid : m1_v_ff;
   assign m2_v_in = m2_rdy ? m1_v_ff  : m2_v_ff;
   assign m3_v_in = m3_rdy ? m2_v_ff  : m3_v_ff;

   assign pp0_in = (2*HW)'(in_dist[HW-1:0])      * (2*HW)'(rate[HW-1:0]);
   assign pp1_in = (HW+RHW)'(in_dist[HW-1:0])    * (HW+RHW)'(rate[HW+RHW-1:HW]);
   assign pp2_in = (2*HW)'(in_dist[2*HW-1:HW])   * (2*HW)'(rate[HW-1:0]);
   assign pp3_in = (HW+RHW)'(in_dist[2*HW-1:HW]) * (HW+RHW)'(rate[HW+RHW-1:HW]);

   assign mid_in  = (2*HW+1)'(pp1_ff) + (2*HW+1)'(pp2_ff);
   assign prod_in = {m2_hi_ff, m2_lo_ff} + (PW'(mid_ff) << HW);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= m1_v_in;
         m2_v_ff <= m2_v_in;
         m3_v_ff <= m3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m1_rdy) begin
         pp0_ff    <= pp0_in;
         pp1_ff    <= pp1_in;
         pp2_ff    <= pp2_in;
         pp3_ff    <= pp3_in;
         m1_fwd_ff <= in_fwd;
      end
      if (m2_rdy) begin
         mid_ff    <= mid_in;
         m2_lo_ff  <= pp0_ff;
         m2_hi_ff  <= pp3_ff;
         m2_fwd_ff <= m1_fwd_ff;
      end
      if (m3_rdy) begin
         prod_ff   <= prod_in;
         m3_fwd_ff <= m2_fwd_ff;
      end
   end

   assign out_valid = m3_v_ff;
   assign out_prod  = prod_ff;
   assign out_fwd   = m3_fwd_ff;

endmodule

// ===== hdl/device_cycle_to_host_time_converter.sv =====
// A request passes the s1, multiplier, s5, s6, s7 and output registers to rsp_.
// Throughput: one request per cycle; every stage holds under back-pressure.
// The rate is set by the three-stage partial-product multiplier and the
// wide signed add, rounding and anchor stages that follow it.
// Reset clears all valid bits and loads the configuration reset values.
// ----------------------------------------------------------------------------
// device_cycle_to_host_time_converter
// Translates a device cycle count into a host timestamp in nanoseconds using
// a fixed-point linear model, with a range error flag.
// ----------------------------------------------------------------------------
module device_cycle_to_host_time_converter #(
   parameter int RATE_FRACTION_BITS   = 32,
   parameter int OFFSET_FRACTION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dcth_pkg::CYCLE_W-1:0]   req_cycle_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dcth_pkg::TIME_W-1:0]    rsp_host_time_ns,
   output logic                           rsp_status,
   input  logic                           csr_write_enable,
   input  logic [dcth_pkg::INDEX_W-1:0]   csr_index,
   input  logic [dcth_pkg::DATA_W-1:0]    csr_write_data
);

   localparam int CF  = (RATE_FRACTION_BITS > OFFSET_FRACTION_BITS) ?
                        RATE_FRACTION_BITS : OFFSET_FRACTION_BITS;
   localparam int RSH = CF - RATE_FRACTION_BITS;
   localparam int OSH = CF - OFFSET_FRACTION_BITS;
   localparam int PW  = dcth_pkg::PROD_W;
   localparam int SW  = PW + RSH + 2;
   localparam int AW  = SW - 1;
   localparam int CW  = dcth_pkg::CYCLE_W;
   localparam int TW  = dcth_pkg::TIME_W;
   localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (CF - 1);

   // Configuration registers.
   logic [CW-1:0]                 ref_cycle_ff;
   logic [TW-1:0]                 anchor_ff;
   logic [dcth_pkg::RATE_W-1:0]   rate_ff;
   logic [dcth_pkg::DATA_W-1:0]   offset_ff;

   // Pipeline control.
   logic s1_v_ff, s1_v_in, s1_rdy;
   logic s5_v_ff, s5_v_in, s5_rdy;
   logic s6_v_ff, s6_v_in, s6_rdy;
   logic s7_v_ff, s7_v_in, s7_rdy;
   logic out_v_ff, out_v_in, out_rdy;
   logic mul_in_ready, mul_out_valid, mul_fwd;
   logic [PW-1:0] mul_prod;

   // Stage payloads.
   logic [CW-1:0]        s1_dist_ff, s1_dist_in;
   logic                 s1_fwd_ff, s1_fwd_in;
   logic [CW:0]          fwd_diff, back_diff;
   logic signed [SW-1:0] prod_ext, off_ext;
   logic signed [SW-1:0] s5_sum_ff, s5_sum_in;
   logic [SW-1:0]        s5_neg_sum;
   logic [AW-1:0]        s6_abs_ff, s6_abs_in;
   logic                 s6_neg_ff;
   logic [AW-1:0]        rounded;
   logic [TW-1:0]        s7_mag_ff;
   logic                 s7_neg_ff, s7_bad_ff, s7_bad_in;
   logic [TW:0]          anchor_sub, anchor_add;
   logic                 final_bad;
   logic [TW-1:0]        final_time;
   logic [TW-1:0]        out_time_ff, out_time_in;
   logic                 out_status_ff, out_status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_cycle_ff <= '0;
         anchor_ff    <= '0;
         rate_ff      <= dcth_pkg::RATE_RESET;
         offset_ff    <= '0;
      end else if (csr_write_enable) begin
         case (dcth_pkg::reg_index_type'(csr_index))
            dcth_pkg::REG_REF_CYCLE:       ref_cycle_ff <= csr_write_data;
            dcth_pkg::REG_HOST_ANCHOR_NS:  anchor_ff    <= csr_write_data;
            dcth_pkg::REG_RATE_NS_PER_CYC: rate_ff <= csr_write_data[dcth_pkg::RATE_W-1:0];
            dcth_pkg::REG_OFFSET_NS:       offset_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Handshake chain: each stage advances when it is empty or drains.
   assign out_rdy   = !out_v_ff || rsp_ready;
   assign s7_rdy    = !s7_v_ff || out_rdy;
   assign s6_rdy    = !s6_v_ff || s7_rdy;
   assign s5_rdy    = !s5_v_ff || s6_rdy;
   assign s1_rdy    = !s1_v_ff || mul_in_ready;
   assign req_ready = s1_rdy;

   assign s1_v_in  = s1_rdy  ? req_valid     : s1_v_ff;
   assign s5_v_in  = s5_rdy  ? mul_out_valid : s5_v_ff;
   assign s6_v_in  = s6_rdy  ? s5_v_ff       : s6_v_ff;
   assign s7_v_in  = s7_rdy  ? s6_v_ff       : s7_v_ff;
   assign out_v_in = out_rdy ? s7_v_ff       : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s5_v_ff  <= s5_v_in;
         s6_v_ff  <= s6_v_in;
         s7_v_ff  <= s7_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Distance from the reference cycle as a magnitude and a direction.
   assign fwd_diff   = {1'b0, req_cycle_count} - {1'b0, ref_cycle_ff};
   assign back_diff  = {1'b0, ref_cycle_ff} - {1'b0, req_cycle_count};
   assign s1_fwd_in  = !fwd_diff[CW];
   assign s1_dist_in = s1_fwd_in ? fwd_diff[CW-1:0] : back_diff[CW-1:0];

   dcth_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_v_ff),
      .in_ready  (mul_in_ready),
      .in_dist   (s1_dist_ff),
      .in_fwd    (s1_fwd_ff),
      .rate      (rate_ff),
      .out_valid (mul_out_valid),
      .out_ready (s5_rdy),
      .out_prod  (mul_prod),
      .out_fwd   (mul_fwd)
   );

   // Both terms aligned to the common fraction before the signed sum.
   assign prod_ext  = $signed(SW'(mul_prod) << RSH);
   assign off_ext   = SW'($signed(offset_ff)) <<< OSH;
   assign s5_sum_in = mul_fwd ? (off_ext + prod_ext) : (off_ext - prod_ext);

   assign s5_neg_sum = SW'(-s5_sum_ff);
   assign s6_abs_in  = s5_sum_ff[SW-1] ? s5_neg_sum[AW-1:0] : s5_sum_ff[AW-1:0];

   // Rounding the magnitude gives ties away from zero for either sign.
   assign rounded   = (s6_abs_ff + ROUND_HALF) >> CF;
   assign s7_bad_in = |rounded[AW-1:TW];

   assign anchor_sub = {1'b0, anchor_ff} - {1'b0, s7_mag_ff};
   assign anchor_add = {1'b0, anchor_ff} + {1'b0, s7_mag_ff};
   assign final_bad  = s7_bad_ff || (s7_neg_ff ? anchor_sub[TW] : anchor_add[TW]);
   assign final_time = s7_neg_ff ? anchor_sub[TW-1:0] : anchor_add[TW-1:0];

   assign out_time_in   = final_bad ? '0 : final_time;
   assign out_status_in = final_bad ? dcth_pkg::STATUS_RANGE : dcth_pkg::STATUS_OK;

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_dist_ff <= s1_dist_in;
         s1_fwd_ff  <= s1_fwd_in;
      end
      if (s5_rdy) begin
         s5_sum_ff <= s5_sum_in;
      end
      if (s6_rdy) begin
         s6_abs_ff <= s6_abs_in;
         s6_neg_ff <= s5_sum_ff[SW-1];
      end
      if (s7_rdy) begin
         s7_mag_ff <= rounded[TW-1:0];
         s7_bad_ff <= s7_bad_in;
         s7_neg_ff <= s6_neg_ff;
      end
      if (out_rdy) begin
         out_time_ff   <= out_time_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_host_time_ns = out_time_ff;
   assign rsp_status       = out_status_ff;

endmodule

// ===== hdl/dcth_checker.sv =====
// ----------------------------------------------------------------------------
// dcth_checker
// Port-level checks for the device cycle to host time converter.
// ----------------------------------------------------------------------------
module dcth_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [dcth_pkg::TIME_W-1:0]    rsp_host_time_ns,
   input logic                           rsp_status
);

   // No result may be offered in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // A range error always carries a zero timestamp.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dcth_pkg::STATUS_RANGE) |-> rsp_host_time_ns == '0)
      else $error("range error with non-zero timestamp");

   // With the output free, the pipeline must be able to take a request.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused although the output is free");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_host_time_ns) && $stable(rsp_status)))
      else $error("stalled result changed or dropped");

endmodule

bind device_cycle_to_host_time_converter dcth_checker u_dcth_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_host_time_ns (rsp_host_time_ns),
   .rsp_status       (rsp_status)
);

// ===== tb/sv/device_cycle_to_host_time_converter_tb.sv =====
// ----------------------------------------------------------------------------
// device_cycle_to_host_time_converter_tb
// Self-checking bench for the cycle to host time converter. Each request is
// predicted with exact wide fixed-point arithmetic and every result is checked
// in order against it. Directed tests cover reset values, rounding, zero
// rate, range errors, extreme settings and one long output stall, then random
// traffic under several settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module device_cycle_to_host_time_converter_tb;

   localparam int RATE_FRAC      = 32;
   localparam int OFFSET_FRAC    = 16;
   localparam int COMMON_FRAC    = (RATE_FRAC > OFFSET_FRAC) ? RATE_FRAC : OFFSET_FRAC;
   localparam int LATENCY        = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 120;
   localparam int PHASE_REQUESTS = 110;

   typedef struct {
      logic [dcth_pkg::TIME_W-1:0] host_time_ns;
      dcth_pkg::status_type        status;
   } host_time_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [dcth_pkg::CYCLE_W-1:0]  req_cycle_count;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [dcth_pkg::TIME_W-1:0]   rsp_host_time_ns;
   logic                          rsp_status;
   logic                          csr_write_enable;
   logic [dcth_pkg::INDEX_W-1:0]  csr_index;
   logic [dcth_pkg::DATA_W-1:0]   csr_write_data;

   // Local copy of the converter settings, updated as each register is written.
   logic [dcth_pkg::CYCLE_W-1:0]  model_ref_cycle;
   logic [dcth_pkg::TIME_W-1:0]   model_host_anchor;
   logic [dcth_pkg::RATE_W-1:0]   model_rate;
   logic [dcth_pkg::DATA_W-1:0]   model_offset;

   host_time_result_type pending_host_times[$];
   host_time_result_type due_result;
   int                   mismatch_count;
   int                   quiet_cycles;
   bit                   idle_enable;
   bit                   hold_request;

   device_cycle_to_host_time_converter #(
      .RATE_FRACTION_BITS  (RATE_FRAC),
      .OFFSET_FRACTION_BITS(OFFSET_FRAC)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cycle_count (req_cycle_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_host_time_ns(rsp_host_time_ns),
      .rsp_status      (rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Exact host time: signed distance times rate plus offset, both at the
   // common fraction, rounded half away from zero and applied to the anchor.
   function automatic host_time_result_type predict_host_time(
      input logic [dcth_pkg::CYCLE_W-1:0] cycle_count);
      host_time_result_type          r;
      logic                          forward;
      logic                          negative;
      logic [dcth_pkg::CYCLE_W-1:0]  distance;
      logic [127:0]                  total;
      logic [127:0]                  offset_term;
      logic [127:0]                  magnitude;
      logic [127:0]                  rounded;
      logic [dcth_pkg::TIME_W:0]     sum;
      forward  = cycle_count >= model_ref_cycle;
      distance = forward ? cycle_count - model_ref_cycle
                         : model_ref_cycle - cycle_count;
      total = (128'(distance) * 128'(model_rate)) << (COMMON_FRAC - RATE_FRAC);
      if (!forward) begin
         total = -total;
      end
      offset_term = {{64{model_offset[63]}}, model_offset} << (COMMON_FRAC - OFFSET_FRAC);
      total       = total + offset_term;
      negative    = total[127];
      magnitude   = negative ? -total : total;
      rounded     = (magnitude + (128'd1 << (COMMON_FRAC - 1))) >> COMMON_FRAC;
      r.host_time_ns = '0;
      r.status       = dcth_pkg::STATUS_RANGE;
      if (rounded[127:64] == '0) begin
         if (negative) begin
            if (rounded[63:0] <= model_host_anchor) begin
               r.host_time_ns = model_host_anchor - rounded[63:0];
               r.status       = dcth_pkg::STATUS_OK;
            end
         end else begin
            sum = {1'b0, model_host_anchor} + {1'b0, rounded[63:0]};
            if (!sum[dcth_pkg::TIME_W]) begin
               r.host_time_ns = sum[dcth_pkg::TIME_W-1:0];
               r.status       = dcth_pkg::STATUS_OK;
            end
         end
      end
      return r;
   endfunction

   // Offers one request after a random gap and records its expected result.
   task automatic send_cycle_count(input logic [dcth_pkg::CYCLE_W-1:0] cycle_count);
      int gap;
      gap = idle_enable ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cycle_count <= cycle_count;
      do @(posedge clock); while (!req_ready);
      pending_host_times.push_back(predict_host_time(cycle_count));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_host_times.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_register(input dcth_pkg::reg_index_type index,
                                 input logic [dcth_pkg::DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      case (index)
         dcth_pkg::REG_REF_CYCLE:       model_ref_cycle   = data;
         dcth_pkg::REG_HOST_ANCHOR_NS:  model_host_anchor = data;
         dcth_pkg::REG_RATE_NS_PER_CYC: model_rate        = data[dcth_pkg::RATE_W-1:0];
         dcth_pkg::REG_OFFSET_NS:       model_offset      = data;
         default: ;
      endcase
   endtask

   // Settings change only once the converter has gone idle.
   task automatic load_model(input logic [63:0] ref_cycle, input logic [63:0] anchor,
                             input logic [63:0] rate, input logic [63:0] offset);
      drain_pipeline();
      write_register(dcth_pkg::REG_REF_CYCLE, ref_cycle);
      write_register(dcth_pkg::REG_HOST_ANCHOR_NS, anchor);
      write_register(dcth_pkg::REG_RATE_NS_PER_CYC, rate);
      write_register(dcth_pkg::REG_OFFSET_NS, offset);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_typical_model();
      logic [63:0] anchor;
      logic [63:0] offset;
      logic [63:0] rate;
      logic [63:0] rate_bits;
      anchor    = random_word();
      offset    = random_word();
      rate_bits = random_word();
      rate   = (64'd1 << 32) + 64'($urandom_range(0, 32'h0200_0000)) - 64'h0100_0000;
      if ($urandom_range(0, 3) == 0) begin
         // Unused upper data bits are set on purpose; only 48 bits are kept.
         rate = {rate_bits[63:36], 4'h0, rate_bits[31:0]};
      end
      load_model(random_word(), {2'b01, anchor[61:0]}, rate,
                 {{13{offset[50]}}, offset[50:0]});
   endtask

   // Mostly cycle counts close to the reference, now and then any value.
   function automatic logic [dcth_pkg::CYCLE_W-1:0] pick_cycle_count();
      logic [63:0] delta;
      int          span;
      case ($urandom_range(0, 9))
         0:       return random_word();
         1:       return $urandom_range(0, 1) ? '0 : '1;
         default: begin
            span  = $urandom_range(0, 40);
            delta = random_word() & ((64'd1 << span) - 64'd1);
            return $urandom_range(0, 1) ? model_ref_cycle + delta
                                        : model_ref_cycle - delta;
         end
      endcase
   endfunction

   task automatic test_reset_values();
      send_cycle_count(64'd0);
      send_cycle_count(64'd1);
      send_cycle_count('1);
      send_cycle_count(64'h8000_0000_0000_0000);
   endtask

   task automatic test_zero_rate();
      load_model(random_word(), 64'd1000, 64'd0, 64'h0000_0000_0005_0000);
      send_cycle_count(64'd0);
      send_cycle_count('1);
      send_cycle_count(random_word());
   endtask

   task automatic test_rounding();
      // Half a nanosecond per cycle puts every odd distance on a tie.
      load_model(64'd2, 64'd1000, 64'h0000_8000_0000, 64'd0);
      send_cycle_count(64'd1);
      send_cycle_count(64'd2);
      send_cycle_count(64'd3);
      // A small negative offset rounds to nothing and leaves the anchor.
      load_model(64'd2, 64'd1000, 64'h0000_8000_0000, -64'sh7FFF);
      send_cycle_count(64'd2);
      send_cycle_count(64'd3);
   endtask

   task automatic test_range_errors();
      load_model(64'd0, 64'd100, 64'h0001_0000_0000, -(64'sd200 << 16));
      send_cycle_count(64'd0);
      send_cycle_count(64'd100);
      send_cycle_count(64'd101);
      load_model('1, '1, '1, 64'd0);
      send_cycle_count(64'd0);
      send_cycle_count('1);
      load_model(64'd0, '1, 64'h0001_0000_0000, 64'd0);
      send_cycle_count(64'd1);
   endtask

   task automatic test_offset_extremes();
      load_model(64'd0, 64'h8000_0000_0000_0000, 64'h0001_0000_0000,
                 64'h7FFF_FFFF_FFFF_FFFF);
      send_cycle_count(64'd0);
      load_model(64'd0, 64'h8000_0000_0000_0000, 64'd1, 64'h8000_0000_0000_0000);
      send_cycle_count(64'd0);
      send_cycle_count('1);
   endtask

   task automatic test_backpressure();
      int n;
      load_typical_model();
      idle_enable  = 1'b0;
      hold_request = 1'b1;
      for (n = 0; n < 48; n++) begin
         send_cycle_count(pick_cycle_count());
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_random_traffic();
      int phase;
      int n;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       load_model(64'd0, 64'd0, 64'd1, 64'h8000_0000_0000_0000);
            1:       load_model('1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF);
            5:       load_model(random_word(), random_word(), random_word(), random_word());
            default: load_typical_model();
         endcase
         idle_enable = (phase != 3) && (phase != 6);
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            send_cycle_count(pick_cycle_count());
         end
      end
      idle_enable = 1'b1;
   endtask

   // Result side: random stalls, plus one long hold when asked for.
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = idle_enable ? $urandom_range(0, 17) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_host_times.size() == 0) begin
            $error("unexpected result: host_time_ns %h status %0d",
                   rsp_host_time_ns, rsp_status);
            mismatch_count++;
         end else begin
            due_result = pending_host_times.pop_front();
            if (rsp_host_time_ns !== due_result.host_time_ns) begin
               $error("host_time_ns: expected %h, got %h",
                      due_result.host_time_ns, rsp_host_time_ns);
               mismatch_count++;
            end
            if (rsp_status !== due_result.status) begin
               $error("status: expected %0d, got %0d", due_result.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      idle_enable      = 1'b1;
      hold_request     = 1'b0;
      model_ref_cycle   = '0;
      model_host_anchor = '0;
      model_rate        = dcth_pkg::RATE_RESET;
      model_offset      = '0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cycle_count  <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= dcth_pkg::REG_REF_CYCLE;
      csr_write_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_zero_rate();
      test_rounding();
      test_range_errors();
      test_offset_extremes();
      test_backpressure();
      test_random_traffic();

      drain_pipeline();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
